### sv/telemetry_frame_receiver_defines.svh
// Assertion macros shared by the telemetry frame receiver checker.
`ifndef TELEMETRY_FRAME_RECEIVER_DEFINES_SVH
`define TELEMETRY_FRAME_RECEIVER_DEFINES_SVH

// Concurrent check, disabled while reset is held.
`define TFR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also covers the reset cycles.
`define TFR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/tfr_pkg.sv
// Types and constants of the telemetry frame receiver.
package tfr_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned VALUE_W    = 24;
    localparam int unsigned LENGTH_W   = 16;
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [BYTE_W-1:0] DELIM_RESET = 8'h7E;
    localparam logic [BYTE_W-1:0] WRAP_RESET  = 8'd7;
    localparam logic [BYTE_W-1:0] WRAP_MIN    = 8'd2;

    // Remainder unit: number of steps and width of its step counter.
    localparam int unsigned DIV_STEPS  = 4;
    localparam int unsigned DIV_STEP_W = $clog2(DIV_STEPS);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_START_DELIM = 1'b0,
        REG_ID_WRAP     = 1'b1
    } t_reg_index;

    typedef enum logic [2:0] {
        PH_WAIT   = 3'd0,
        PH_LEN_HI = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_ID     = 3'd3,
        PH_D2     = 3'd4,
        PH_D1     = 3'd5,
        PH_D0     = 3'd6,
        PH_CHECK  = 3'd7
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0]   frame_id;
        logic [VALUE_W-1:0]  frame_value;
        logic [LENGTH_W-1:0] frame_length;
        logic                checksum_ok;
    } t_frame_info;

    typedef struct packed {
        logic [BYTE_W-1:0] dividend;
        logic [BYTE_W-1:0] wrap;
        logic              neg;
        logic              force_zero;
    } t_lost_req;

endpackage

### sv/tfr_ifs.sv
// Valid/ready channel interfaces for received bytes and decoded frames.
interface tfr_byte_if;
    import tfr_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tfr_frame_if;
    import tfr_pkg::*;

    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   frame_id;
    logic [VALUE_W-1:0]  frame_value;
    logic [LENGTH_W-1:0] frame_length;
    logic                checksum_ok;
    logic [BYTE_W-1:0]   lost_count;

    modport source (output valid, output frame_id, output frame_value,
                    output frame_length, output checksum_ok, output lost_count,
                    input ready);
    modport sink   (input valid, input frame_id, input frame_value,
                    input frame_length, input checksum_ok, input lost_count,
                    output ready);
endinterface

### sv/telemetry_frame_receiver.sv
// Telemetry frame receiver: byte-serial frame parser with checksum and gap count.
//
// Usage:
//   i_rx carries one received byte per transaction. The parser hunts for the
//   start delimiter, then takes length high, length low, identifier, three
//   data bytes and the checksum byte. The checksum byte produces one
//   transaction on o_frame: identifier, 24-bit value, length, checksum flag
//   and the number of identifiers skipped since the previous frame, modulo
//   id_wrap (zero on the first frame after reset or when id_wrap is below 2).
//   Throughput is one byte per cycle; i_rx.ready is high on every byte except
//   a checksum byte that arrives while the previous frame's result is still
//   held in the remainder unit behind a stalled o_frame.
//   o_frame.valid rises once the remainder unit, which retires two
//   dividend bits per cycle, has loaded its result into the result register.
//   A stalled o_frame holds its result; the parser takes bytes up to the checksum.
//   Configuration (i_cfg_*) writes land at the edge where i_cfg_we is high.
//   Reset (synchronous, active low) returns the parser to delimiter hunt,
//   drops any pending result and restores delimiter 0x7E and id_wrap 7.
module telemetry_frame_receiver (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tfr_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [tfr_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    tfr_byte_if.sink                            i_rx,
    tfr_frame_if.source                         o_frame
);
    import tfr_pkg::*;

    // Configuration registers.
    logic [BYTE_W-1:0]   r_delim;
    logic [BYTE_W-1:0]   r_wrap;

    // Parser state and frame fields collected so far.
    t_phase              r_phase;
    t_phase              n_phase;
    logic [BYTE_W-1:0]   r_len_hi;
    logic [BYTE_W-1:0]   r_len_lo;
    logic [BYTE_W-1:0]   r_cur_id;
    logic [VALUE_W-1:0]  r_value;
    logic [BYTE_W-1:0]   r_sum;
    logic [BYTE_W-1:0]   r_prev_id;
    logic                r_seen;

    // Result register.
    logic                r_out_valid;
    t_frame_info         r_out_info;
    logic [BYTE_W-1:0]   r_out_lost;

    logic                rx_acc;
    logic                check_fire;
    logic [BYTE_W:0]     gap;
    t_lost_req           req;
    t_frame_info         info;
    logic                div_idle;
    logic                div_done;
    logic [BYTE_W-1:0]   div_lost;
    t_frame_info         div_info;
    logic                drain;

    assign i_rx.ready = (r_phase != PH_CHECK) || div_idle;
    assign rx_acc     = i_rx.valid && i_rx.ready;
    assign check_fire = rx_acc && (r_phase == PH_CHECK);

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= DELIM_RESET;
            r_wrap  <= WRAP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_START_DELIM: r_delim <= i_cfg_data;
                REG_ID_WRAP:     r_wrap  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- parser state machine ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_phase = r_phase;
        if (rx_acc) begin
            case (r_phase)
                PH_WAIT: begin
                    if (i_rx.rx_byte == r_delim) begin
                        n_phase = PH_LEN_HI;
                    end
                end
                PH_LEN_HI: n_phase = PH_LEN_LO;
                PH_LEN_LO: n_phase = PH_ID;
                PH_ID:     n_phase = PH_D2;
                PH_D2:     n_phase = PH_D1;
                PH_D1:     n_phase = PH_D0;
                PH_D0:     n_phase = PH_CHECK;
                PH_CHECK:  n_phase = PH_WAIT;
                default:   n_phase = PH_WAIT;
            endcase
        end
    end

    // Capture frame bytes; keep a running 8-bit checksum over id and data.
    always_ff @(posedge i_clk) begin
        if (rx_acc) begin
            case (r_phase)
                PH_LEN_HI: r_len_hi <= i_rx.rx_byte;
                PH_LEN_LO: r_len_lo <= i_rx.rx_byte;
                PH_ID: begin
                    r_cur_id <= i_rx.rx_byte;
                    r_sum    <= i_rx.rx_byte;
                end
                PH_D2: begin
                    r_value[23:16] <= i_rx.rx_byte;
                    r_sum          <= r_sum + i_rx.rx_byte;
                end
                PH_D1: begin
                    r_value[15:8] <= i_rx.rx_byte;
                    r_sum         <= r_sum + i_rx.rx_byte;
                end
                PH_D0: begin
                    r_value[7:0] <= i_rx.rx_byte;
                    r_sum        <= r_sum + i_rx.rx_byte;
                end
                default: ;
            endcase
        end
    end

    // The identifier of every completed frame, good checksum or not,
    // becomes the reference for the next gap.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_id <= '0;
            r_seen    <= 1'b0;
        end else if (check_fire) begin
            r_prev_id <= r_cur_id;
            r_seen    <= 1'b1;
        end
    end

    // ---------------- frame completion ----------------
    // Gap = id - prev - 1 in 9-bit two's complement. For a negative gap the
    // remainder unit works on its one's complement and folds it back.
    assign gap = {1'b0, r_cur_id} - {1'b0, r_prev_id} - 9'd1;

    always_comb begin
        req.neg        = gap[BYTE_W];
        req.dividend   = gap[BYTE_W] ? ~gap[BYTE_W-1:0] : gap[BYTE_W-1:0];
        req.wrap       = r_wrap;
        req.force_zero = !r_seen || (r_wrap < WRAP_MIN);

        info.frame_id     = r_cur_id;
        info.frame_value  = r_value;
        info.frame_length = {r_len_hi, r_len_lo};
        info.checksum_ok  = (i_rx.rx_byte == ~r_sum);
    end

    tfr_lost_div u_lost_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (check_fire),
        .i_req   (req),
        .i_info  (info),
        .i_drain (drain),
        .o_idle  (div_idle),
        .o_done  (div_done),
        .o_lost  (div_lost),
        .o_info  (div_info)
    );

    // ---------------- result register ----------------
    // Advance a finished result when the register is empty or being taken.
    assign drain = !r_out_valid || o_frame.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (div_done && drain) begin
            r_out_valid <= 1'b1;
        end else if (o_frame.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_done && drain) begin
            r_out_info <= div_info;
            r_out_lost <= div_lost;
        end
    end

    assign o_frame.valid        = r_out_valid;
    assign o_frame.frame_id     = r_out_info.frame_id;
    assign o_frame.frame_value  = r_out_info.frame_value;
    assign o_frame.frame_length = r_out_info.frame_length;
    assign o_frame.checksum_ok  = r_out_info.checksum_ok;
    assign o_frame.lost_count   = r_out_lost;

endmodule

### sv/tfr_lost_div.sv
// Iterative remainder unit that turns an identifier gap into the lost count.
module tfr_lost_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  tfr_pkg::t_lost_req  i_req,
    input  tfr_pkg::t_frame_info i_info,
    input  logic                i_drain,
    output logic                o_idle,
    output logic                o_done,
    output logic [tfr_pkg::BYTE_W-1:0] o_lost,
    output tfr_pkg::t_frame_info o_info
);
    import tfr_pkg::*;

    function automatic logic [BYTE_W-1:0] rem_step(input logic [BYTE_W-1:0] rem,
                                                   input logic bit_in,
                                                   input logic [BYTE_W-1:0] dvs);
        logic [BYTE_W:0] t;
        t = {rem, bit_in};
        if (t >= {1'b0, dvs}) begin
            t = t - {1'b0, dvs};
        end
        return t[BYTE_W-1:0];
    endfunction

    logic                  r_busy;
    logic [DIV_STEP_W-1:0] r_step;
    logic [BYTE_W-1:0]     r_rem;
    logic [BYTE_W-1:0]     r_dvd;
    logic [BYTE_W-1:0]     r_wrap;
    logic                  r_neg;
    logic                  r_zero;
    t_frame_info           r_info;

    logic [BYTE_W-1:0] rem_a;
    logic [BYTE_W-1:0] rem_b;
    logic              last;
    logic              advance;

    // Two restoring steps per cycle, most significant dividend bits first.
    assign rem_a   = rem_step(r_rem, r_dvd[BYTE_W-1], r_wrap);
    assign rem_b   = rem_step(rem_a, r_dvd[BYTE_W-2], r_wrap);
    assign last    = r_busy && (r_step == DIV_STEP_W'(DIV_STEPS - 1));
    assign advance = r_busy && !(last && !i_drain);

    assign o_done = last;
    assign o_idle = !r_busy || (last && i_drain);
    assign o_info = r_info;

    // A negative gap of -k maps to wrap-1 - ((k-1) mod wrap).
    always_comb begin
        if (r_zero) begin
            o_lost = '0;
        end else if (r_neg) begin
            o_lost = r_wrap - 8'd1 - rem_b;
        end else begin
            o_lost = rem_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (advance) begin
            if (last) begin
                r_busy <= 1'b0;
            end else begin
                r_step <= r_step + DIV_STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_dvd  <= i_req.dividend;
            r_wrap <= i_req.wrap;
            r_neg  <= i_req.neg;
            r_zero <= i_req.force_zero;
            r_info <= i_info;
        end else if (advance) begin
            r_rem <= rem_b;
            r_dvd <= {r_dvd[BYTE_W-3:0], 2'b00};
        end
    end

endmodule

### sv/tfr_checker.sv
// Port-level assertion checker for the telemetry frame receiver, with its bind.
`include "telemetry_frame_receiver_defines.svh"

module tfr_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_cfg_we,
    input logic [tfr_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input logic [tfr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [tfr_pkg::BYTE_W-1:0]      i_frame_id,
    input logic [tfr_pkg::VALUE_W-1:0]     i_frame_value,
    input logic [tfr_pkg::LENGTH_W-1:0]    i_frame_length,
    input logic                            i_checksum_ok,
    input logic [tfr_pkg::BYTE_W-1:0]      i_lost_count
);
    import tfr_pkg::*;

    // Shadow of the id_wrap register as seen on the configuration port.
    logic [BYTE_W-1:0] r_wrap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap <= WRAP_RESET;
        end else if (i_cfg_we && (i_cfg_index == REG_ID_WRAP)) begin
            r_wrap <= i_cfg_data;
        end
    end

    `TFR_ASSERT_ALWAYS(a_reset_drops_result, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")
    `TFR_ASSERT(a_valid_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "result dropped while stalled")
    `TFR_ASSERT(a_payload_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable(i_frame_id) && $stable(i_frame_value) && $stable(i_frame_length) && $stable(i_checksum_ok) && $stable(i_lost_count), "result changed while stalled")
    `TFR_ASSERT(a_lost_in_range, i_clk, i_rst_n, i_out_valid |-> (i_lost_count == 8'd0) || (i_lost_count < r_wrap), "lost count outside the wrap range")

endmodule

bind telemetry_frame_receiver tfr_checker u_tfr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_cfg_we       (i_cfg_we),
    .i_cfg_index    (i_cfg_index),
    .i_cfg_data     (i_cfg_data),
    .i_out_valid    (o_frame.valid),
    .i_out_ready    (o_frame.ready),
    .i_frame_id     (o_frame.frame_id),
    .i_frame_value  (o_frame.frame_value),
    .i_frame_length (o_frame.frame_length),
    .i_checksum_ok  (o_frame.checksum_ok),
    .i_lost_count   (o_frame.lost_count)
);
